### rtl/biou_pkg.sv
`timescale 1ns / 1ps

package biou_pkg;

    // request field positions inside s_tdata, in units of one coordinate
    localparam int unsigned FLD_A_LEFT   = 0;
    localparam int unsigned FLD_A_TOP    = 1;
    localparam int unsigned FLD_A_WIDTH  = 2;
    localparam int unsigned FLD_A_HEIGHT = 3;
    localparam int unsigned FLD_B_LEFT   = 4;
    localparam int unsigned FLD_B_TOP    = 5;
    localparam int unsigned FLD_B_WIDTH  = 6;
    localparam int unsigned FLD_B_HEIGHT = 7;
    localparam int unsigned NUM_FIELDS   = 8;

    localparam int unsigned BYTE_BITS = 8;

    // number of front stages ahead of the divider
    localparam int unsigned FRONT_STAGES = 4;

endpackage

### rtl/box_iou_ratio_core.sv
`timescale 1ns / 1ps

// Box intersection-over-union core.
// Slave channel (s_*): one request per accepted beat, two boxes packed in s_tdata
// as left, top, width, height of box a, then of box b, COORD_BITS each.
// Master channel (m_*): one result per request, in request order, with the
// floored ratio (FRACTION_BITS fraction bits), intersection area and union area.
// Each request passes through FRACTION_BITS + 5 register stages: four front stages
// (edges, spans, area multipliers, union) followed by one restoring-division stage
// per quotient bit.
// Throughput: one request per cycle while m_tready is high; every stage holds a valid bit and moves
// whenever the stage after it is empty or moving, so bubbles close up.
// When m_tready is low the last stage holds its result and the stages behind it
// keep filling; s_tready falls only once every stage holds a request.
// Reset (aresetn low, synchronous) clears all valid bits; no request in flight
// survives it. Nothing is kept from one request to the next.
module box_iou_ratio_core #(
    parameter int unsigned COORD_BITS    = 12,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // a_left, a_top, a_width, a_height, b_left, b_top, b_width, b_height
    input  logic [biou_pkg::NUM_FIELDS*COORD_BITS-1:0] s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // overlap_ratio, intersection_area, union_area, zero fill
    output logic [((FRACTION_BITS+4*COORD_BITS+3+biou_pkg::BYTE_BITS-1)
                   /biou_pkg::BYTE_BITS)*biou_pkg::BYTE_BITS-1:0] m_tdata
);
    import biou_pkg::*;

    localparam int unsigned C     = COORD_BITS;
    localparam int unsigned E     = COORD_BITS + 1;
    localparam int unsigned A     = 2 * COORD_BITS + 1;
    localparam int unsigned FB    = FRACTION_BITS;
    localparam int unsigned R     = FRACTION_BITS + 1;
    localparam int unsigned OUT_W = ((R + 2 * A + BYTE_BITS - 1) / BYTE_BITS) * BYTE_BITS;

    // ---------------- stage 1: far edges and extents ----------------
    logic         s1_valid_reg;
    logic         s1_ready;
    logic [E-1:0] s1_ax0_reg, s1_ax1_reg, s1_ay0_reg, s1_ay1_reg;
    logic [E-1:0] s1_bx0_reg, s1_bx1_reg, s1_by0_reg, s1_by1_reg;
    logic [E-1:0] s1_aw1_reg, s1_ah1_reg, s1_bw1_reg, s1_bh1_reg;

    logic [C-1:0] a_left, a_top, a_width, a_height;
    logic [C-1:0] b_left, b_top, b_width, b_height;

    assign a_left   = s_tdata[FLD_A_LEFT*C   +: C];
    assign a_top    = s_tdata[FLD_A_TOP*C    +: C];
    assign a_width  = s_tdata[FLD_A_WIDTH*C  +: C];
    assign a_height = s_tdata[FLD_A_HEIGHT*C +: C];
    assign b_left   = s_tdata[FLD_B_LEFT*C   +: C];
    assign b_top    = s_tdata[FLD_B_TOP*C    +: C];
    assign b_width  = s_tdata[FLD_B_WIDTH*C  +: C];
    assign b_height = s_tdata[FLD_B_HEIGHT*C +: C];

    // ---------------- stage 2: clamped spans ----------------
    logic         s2_valid_reg;
    logic         s2_ready;
    logic [E-1:0] s2_span_x_reg, s2_span_y_reg;
    logic [E-1:0] s2_aw1_reg, s2_ah1_reg, s2_bw1_reg, s2_bh1_reg;

    // ---------------- stage 3: areas ----------------
    logic         s3_valid_reg;
    logic         s3_ready;
    logic [A-1:0] s3_inter_reg, s3_area_a_reg, s3_area_b_reg;

    // ---------------- stage 4: union ----------------
    logic         s4_valid_reg;
    logic         s4_ready;
    logic [A-1:0] s4_inter_reg, s4_uni_reg;

    // ---------------- divider stages ----------------
    logic [FB:0]  dv_valid_reg;
    logic [FB:0]  dv_ready;
    logic [A-1:0] dv_rem_reg   [0:FB];
    logic [R-1:0] dv_quo_reg   [0:FB];
    logic [A-1:0] dv_inter_reg [0:FB];
    logic [A-1:0] dv_uni_reg   [0:FB];

    assign s_tready = s1_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s4_ready = !s4_valid_reg || dv_ready[0];

    // stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= s_tvalid;
        end
        if (s1_ready && s_tvalid) begin
            s1_ax0_reg <= {1'b0, a_left};
            s1_ax1_reg <= {1'b0, a_left} + {1'b0, a_width};
            s1_ay0_reg <= {1'b0, a_top};
            s1_ay1_reg <= {1'b0, a_top} + {1'b0, a_height};
            s1_bx0_reg <= {1'b0, b_left};
            s1_bx1_reg <= {1'b0, b_left} + {1'b0, b_width};
            s1_by0_reg <= {1'b0, b_top};
            s1_by1_reg <= {1'b0, b_top} + {1'b0, b_height};
            s1_aw1_reg <= {1'b0, a_width} + E'(1);
            s1_ah1_reg <= {1'b0, a_height} + E'(1);
            s1_bw1_reg <= {1'b0, b_width} + E'(1);
            s1_bh1_reg <= {1'b0, b_height} + E'(1);
        end
    end

    // stage 2
    logic [E-1:0] lo_x, hi_x, lo_y, hi_y;
    logic [E-1:0] span_x_next, span_y_next;

    always_comb begin
        lo_x = (s1_ax0_reg > s1_bx0_reg) ? s1_ax0_reg : s1_bx0_reg;
        hi_x = (s1_ax1_reg < s1_bx1_reg) ? s1_ax1_reg : s1_bx1_reg;
        lo_y = (s1_ay0_reg > s1_by0_reg) ? s1_ay0_reg : s1_by0_reg;
        hi_y = (s1_ay1_reg < s1_by1_reg) ? s1_ay1_reg : s1_by1_reg;
        span_x_next = (hi_x < lo_x) ? '0 : hi_x - lo_x + E'(1);
        span_y_next = (hi_y < lo_y) ? '0 : hi_y - lo_y + E'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_span_x_reg <= span_x_next;
            s2_span_y_reg <= span_y_next;
            s2_aw1_reg    <= s1_aw1_reg;
            s2_ah1_reg    <= s1_ah1_reg;
            s2_bw1_reg    <= s1_bw1_reg;
            s2_bh1_reg    <= s1_bh1_reg;
        end
    end

    // stage 3: three narrow multipliers side by side
    logic [2*E-1:0] inter_prod, area_a_prod, area_b_prod;

    assign inter_prod  = s2_span_x_reg * s2_span_y_reg;
    assign area_a_prod = s2_aw1_reg * s2_ah1_reg;
    assign area_b_prod = s2_bw1_reg * s2_bh1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            s3_valid_reg <= s2_valid_reg;
        end
        if (s3_ready && s2_valid_reg) begin
            s3_inter_reg  <= inter_prod[A-1:0];
            s3_area_a_reg <= area_a_prod[A-1:0];
            s3_area_b_reg <= area_b_prod[A-1:0];
        end
    end

    // stage 4
    logic [A:0] uni_sum;

    assign uni_sum = {1'b0, s3_area_a_reg} + {1'b0, s3_area_b_reg} - {1'b0, s3_inter_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (s4_ready) begin
            s4_valid_reg <= s3_valid_reg;
        end
        if (s4_ready && s3_valid_reg) begin
            s4_inter_reg <= s3_inter_reg;
            s4_uni_reg   <= uni_sum[A-1:0];
        end
    end

    // restoring division, one quotient bit per stage, msb first
    genvar j;
    generate
        for (j = 0; j <= FB; j++) begin : g_div
            logic         prev_valid;
            logic [A-1:0] prev_inter;
            logic [A-1:0] prev_uni;
            logic [R-1:0] prev_quo;
            logic [A:0]   trial;
            logic [A:0]   diff;
            logic         qbit;

            if (j == 0) begin : g_first
                assign prev_valid = s4_valid_reg;
                assign prev_inter = s4_inter_reg;
                assign prev_uni   = s4_uni_reg;
                assign prev_quo   = '0;
                // intersection never exceeds the union, so this bit is the integer part
                assign trial      = {1'b0, s4_inter_reg};
            end else begin : g_next
                assign prev_valid = dv_valid_reg[j-1];
                assign prev_inter = dv_inter_reg[j-1];
                assign prev_uni   = dv_uni_reg[j-1];
                assign prev_quo   = dv_quo_reg[j-1];
                assign trial      = {dv_rem_reg[j-1], 1'b0};
            end

            if (j == FB) begin : g_last
                assign dv_ready[j] = !dv_valid_reg[j] || m_tready;
            end else begin : g_mid
                assign dv_ready[j] = !dv_valid_reg[j] || dv_ready[j+1];
            end

            assign diff = trial - {1'b0, prev_uni};
            assign qbit = (trial >= {1'b0, prev_uni});

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    dv_valid_reg[j] <= 1'b0;
                end else if (dv_ready[j]) begin
                    dv_valid_reg[j] <= prev_valid;
                end
                if (dv_ready[j] && prev_valid) begin
                    dv_rem_reg[j]   <= qbit ? diff[A-1:0] : trial[A-1:0];
                    dv_quo_reg[j]   <= {prev_quo[R-2:0], qbit};
                    dv_inter_reg[j] <= prev_inter;
                    dv_uni_reg[j]   <= prev_uni;
                end
            end
        end
    endgenerate

    assign m_tvalid = dv_valid_reg[FB];
    assign m_tdata  = OUT_W'({dv_uni_reg[FB], dv_inter_reg[FB], dv_quo_reg[FB]});

    // ---------------- checks ----------------
    a_union_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> dv_uni_reg[FB] != '0)
        else $error("union area of zero at output");

    a_inter_le_union: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> dv_inter_reg[FB] <= dv_uni_reg[FB])
        else $error("intersection larger than union");

    a_ratio_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> dv_quo_reg[FB] <= (R'(1) << FB))
        else $error("ratio above one");

    a_ratio_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && dv_quo_reg[FB] == (R'(1) << FB)) |->
        dv_inter_reg[FB] == dv_uni_reg[FB])
        else $error("full ratio without full overlap");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage is empty");

endmodule
